[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (ante) |-> (cons)) else $error("implication check failed");

// Check that a condition is never seen outside reset.
`define ASSERT_NEVER(label, clock, reset_n, cond) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        !(cond)) else $error("forbidden condition seen");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons)
`define ASSERT_NEVER(label, clock, reset_n, cond)
`define ASSERT_NEXT(label, clock, reset_n, ante, cons)

`endif

`endif

[rtl/umpq_pkg.sv]
package umpq_pkg;

    // Store geometry; the count and index widths follow from the capacity
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int INDEX_BITS = $clog2(CAPACITY);

    // Command codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                         action;
        logic signed [VALUE_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [VALUE_BITS-1:0] max_value;
        logic [COUNT_BITS-1:0]        count;
        logic                         is_empty;
    } result_t;

endpackage

[rtl/unsorted_max_priority_queue_core.sv]
// Channel  | Signals                             | Transaction
// ---------+-------------------------------------+----------------------------------
// command  | cmd_valid, cmd_stall, cmd           | enqueue a value or dequeue the max
// result   | result_valid, result_stall, result  | status, removed value, entry count, empty flag
//
// A microcoded sequencer runs each command; a new command is taken only in the wait step.
// A dequeue on a non-empty store runs a scan loop that reads one held entry per cycle through one read port.
// The removed slot is refilled with the last held entry, so no shifting pass is needed.
// Reset clears the entry count and the sequencer; the store needs no clearing pass.
// A stalled result holds in the output register; the sequencer waits in its emit step.
`include "assert_macros.svh"

module unsorted_max_priority_queue_core
    import umpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    input  cmd_t    cmd,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [2:0] {
        S_WAIT, S_DISPATCH, S_DEQ_START, S_SCAN, S_FINISH, S_ENQ, S_NO_ENTRY, S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS, C_NO_CMD, C_IS_ENQ, C_EMPTY, C_SCAN_MORE, C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take;       // accept a command transaction
        logic  rd_scan;    // read address from scan pointer or last entry, else entry zero
        logic  scan_init;  // start a scan
        logic  scan_step;  // compare one entry and advance
        logic  enq;        // append the command value
        logic  fill;       // move the last entry into the removed slot
        logic  no_entry;   // report a dequeue on an empty store
        logic  emit;       // load the result register
        cond_t cond;       // jump condition
        step_t target;     // jump target; otherwise fall through to next step
    } ctrl_t;

    // Microcode table: one control word per step
    function automatic ctrl_t microcode(input step_t s);
        ctrl_t w;
        w = '0;
        w.cond   = C_ALWAYS;
        w.target = S_WAIT;
        unique case (s)
            S_WAIT:      begin w.take = 1'b1; w.cond = C_NO_CMD; w.target = S_WAIT; end
            S_DISPATCH:  begin w.cond = C_IS_ENQ; w.target = S_ENQ; end
            S_DEQ_START: begin
                w.scan_init = 1'b1;
                w.cond      = C_EMPTY;
                w.target    = S_NO_ENTRY;
            end
            S_SCAN:      begin
                w.rd_scan   = 1'b1;
                w.scan_step = 1'b1;
                w.cond      = C_SCAN_MORE;
                w.target    = S_SCAN;
            end
            S_FINISH:    begin w.fill = 1'b1; w.target = S_EMIT; end
            S_ENQ:       begin w.enq = 1'b1; w.target = S_EMIT; end
            S_NO_ENTRY:  begin w.no_entry = 1'b1; w.target = S_EMIT; end
            S_EMIT:      begin w.emit = 1'b1; w.cond = C_OUT_BUSY; w.target = S_EMIT; end
            default:     begin w.target = S_WAIT; end
        endcase
        return w;
    endfunction

    logic signed [VALUE_BITS-1:0] store_mem [CAPACITY];

    step_t                        step_reg, step_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [COUNT_BITS-1:0]        ptr_reg, ptr_next;
    logic                         result_valid_reg, result_valid_next;
    cmd_t                         cmd_reg;
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] best_reg;
    logic [INDEX_BITS-1:0]        best_idx_reg;
    logic [1:0]                   res_status_reg;
    logic signed [VALUE_BITS-1:0] res_max_reg;
    result_t                      result_reg;

    ctrl_t                        ctrl;
    logic                         cond_true;
    logic                         cmd_fire;
    logic                         out_busy;
    logic                         emit_fire;
    logic                         full;
    logic                         scan_more;
    logic [COUNT_BITS-1:0]        count_dec;
    logic [COUNT_BITS-1:0]        ptr_dec;
    logic [INDEX_BITS-1:0]        rd_addr;
    logic                         wr_en;
    logic [INDEX_BITS-1:0]        wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;

    // Decode the current step
    assign ctrl      = microcode(step_reg);
    assign cmd_stall = !ctrl.take;
    assign cmd_fire  = cmd_valid && ctrl.take;
    assign out_busy  = result_valid_reg && result_stall;
    assign emit_fire = ctrl.emit && !out_busy;

    assign full      = (count_reg == COUNT_BITS'(CAPACITY));
    assign scan_more = (ptr_reg != count_reg);
    assign count_dec = count_reg - COUNT_BITS'(1);
    assign ptr_dec   = ptr_reg - COUNT_BITS'(1);

    // Select the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_CMD:    cond_true = !cmd_valid;
            C_IS_ENQ:    cond_true = (cmd_reg.action == ACT_ENQ);
            C_EMPTY:     cond_true = (count_reg == '0);
            C_SCAN_MORE: cond_true = scan_more;
            C_OUT_BUSY:  cond_true = out_busy;
            default:     cond_true = 1'b1;
        endcase
    end

    // Sequence: jump on condition, else fall through (emit wraps to wait)
    always_comb
    begin
        if (cond_true)
            step_next = ctrl.target;
        else
            step_next = step_t'(3'(step_reg + 3'd1));
    end

    // Pick the store read address: zero, the scan pointer, or the last entry
    always_comb
    begin
        if (!ctrl.rd_scan)
            rd_addr = '0;
        else if (scan_more)
            rd_addr = ptr_reg[INDEX_BITS-1:0];
        else
            rd_addr = count_dec[INDEX_BITS-1:0];
    end

    // Drive the store write port: append or refill
    assign wr_en   = (ctrl.enq && !full) || ctrl.fill;
    assign wr_addr = ctrl.fill ? best_idx_reg : count_reg[INDEX_BITS-1:0];
    assign wr_data = ctrl.fill ? rd_data_reg : cmd_reg.value;

    // Update count, scan pointer and output valid
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq && !full)
            count_next = count_reg + COUNT_BITS'(1);
        else if (ctrl.fill)
            count_next = count_dec;

        ptr_next = ptr_reg;
        if (ctrl.scan_init)
            ptr_next = COUNT_BITS'(1);
        else if (ctrl.scan_step && scan_more)
            ptr_next = ptr_reg + COUNT_BITS'(1);

        result_valid_next = result_valid_reg;
        if (emit_fire)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    // Hold sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= S_WAIT;
            count_reg        <= '0;
            ptr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            count_reg        <= count_next;
            ptr_reg          <= ptr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[rd_addr];
    end

    // Datapath: capture command, track the maximum, stage the result
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            cmd_reg <= cmd;

        if (ctrl.scan_init)
        begin
            best_reg     <= {1'b1, {(VALUE_BITS-1){1'b0}}};
            best_idx_reg <= '0;
        end
        else if (ctrl.scan_step && (rd_data_reg >= best_reg))
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= ptr_dec[INDEX_BITS-1:0];
        end

        if (ctrl.enq)
        begin
            res_status_reg <= full ? ST_FULL : ST_OK;
            res_max_reg    <= '0;
        end
        else if (ctrl.fill)
        begin
            res_status_reg <= ST_OK;
            res_max_reg    <= best_reg;
        end
        else if (ctrl.no_entry)
        begin
            res_status_reg <= ST_EMPTY;
            res_max_reg    <= '0;
        end

        if (emit_fire)
        begin
            result_reg.status    <= res_status_reg;
            result_reg.max_value <= res_max_reg;
            result_reg.count     <= count_reg;
            result_reg.is_empty  <= (count_reg == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks on the sequencer and the store bookkeeping
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > COUNT_BITS'(CAPACITY))
    `ASSERT_IMPLIES(a_scan_range, clk, rst_n, step_reg == S_SCAN,
                    (ptr_reg != '0) && (ptr_reg <= count_reg))
    `ASSERT_IMPLIES(a_full_status, clk, rst_n, emit_fire && (res_status_reg == ST_FULL),
                    count_reg == COUNT_BITS'(CAPACITY))
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_busy, result_valid_reg)

endmodule

[bench/unsorted_max_priority_queue_core_test.sv]
`timescale 1ns / 100ps

module unsorted_max_priority_queue_core_test;
    import umpq_pkg::*;

    localparam int RANDOM_ITEMS   = 950;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 250;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 33;
    localparam int QUIET_FIRST    = 450;
    localparam int QUIET_LAST     = 650;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_stall;
    cmd_t    cmd = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Commands waiting to be driven, results waiting to be seen
    cmd_t                         pending_cmds[$];
    result_t                      expected_results[$];
    // Held priority values in arrival order
    logic signed [VALUE_BITS-1:0] held_values[$];

    int error_count   = 0;
    int cmds_sent     = 0;
    int results_seen  = 0;
    int full_drops    = 0;
    int empty_deqs    = 0;
    int removed_count = 0;
    int peak_count    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int idle_cycles   = 0;

    unsorted_max_priority_queue_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one command to the queue image and return the result it should give
    function automatic result_t queue_model_step(cmd_t c);
        result_t r;
        int      best;
        int      i;
        r = '0;
        if (c.action == ACT_ENQ)
        begin
            if (held_values.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                r.status = ST_OK;
                held_values.insert(held_values.size(), c.value);
            end
        end
        else
        begin
            if (held_values.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                best = 0;
                for (i = 1; i < held_values.size(); i++)
                    if (held_values[i] > held_values[best])
                        best = i;
                r.status    = ST_OK;
                r.max_value = held_values[best];
                held_values.delete(best);
                removed_count++;
            end
        end
        if (held_values.size() > peak_count)
            peak_count = held_values.size();
        r.count    = COUNT_BITS'(held_values.size());
        r.is_empty = (held_values.size() == 0);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic act, logic signed [VALUE_BITS-1:0] v);
        cmd_t c;
        c.action = act;
        c.value  = v;
        return c;
    endfunction

    // Append one command to the pending list
    task automatic add_cmd(logic act, logic signed [VALUE_BITS-1:0] v);
        pending_cmds.insert(pending_cmds.size(), make_cmd(act, v));
    endtask

    // Mix of full-range words, extremes and a narrow band that forces ties
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic signed [VALUE_BITS-1:0] v;
        case ($urandom_range(9))
            0: v = VALUE_MAX;
            1: v = VALUE_MIN;
            2, 3, 4:
            begin
                v = $urandom_range(15);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %0d ns: result %0d %s: got %0h, expected %0h",
                 $time, results_seen, what, got, want);
        error_count++;
    endtask

    // Driver: record accepted transaction, then offer the next pending command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_results.insert(expected_results.size(), queue_model_step(cmd));
                cmds_sent++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_cmds.size() != 0 &&
                    ($urandom_range(99) >= IDLE_PCT ||
                     (cmds_sent >= QUIET_FIRST && cmds_sent < QUIET_LAST)))
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 64'(result), 64'd0);
                else
                begin
                    if (result.status != expected_results[0].status)
                        report_mismatch("status", 64'(result.status),
                                        64'(expected_results[0].status));
                    if (result.max_value != expected_results[0].max_value)
                        report_mismatch("max_value", 64'(result.max_value),
                                        64'(expected_results[0].max_value));
                    if (result.count != expected_results[0].count)
                        report_mismatch("count", 64'(result.count),
                                        64'(expected_results[0].count));
                    if (result.is_empty != expected_results[0].is_empty)
                        report_mismatch("is_empty", 64'(result.is_empty),
                                        64'(expected_results[0].is_empty));
                    case (expected_results[0].status)
                        ST_FULL:  full_drops++;
                        ST_EMPTY: empty_deqs++;
                        default:  ;
                    endcase
                    expected_results.pop_front();
                end
                results_seen++;
            end
            // Hold off once for a long stretch so the block backs up its input
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("TIMEOUT: no transaction for %0d cycles", idle_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int n;
        int seg_len;
        int enq_pct;
        int k;
        logic act;

        // Directed: empty dequeue, extremes, ties, drain past empty
        add_cmd(ACT_DEQ, VALUE_MAX);
        add_cmd(ACT_ENQ, VALUE_MAX);
        add_cmd(ACT_ENQ, VALUE_MIN);
        add_cmd(ACT_ENQ, '0);
        add_cmd(ACT_ENQ, -1);
        add_cmd(ACT_ENQ, 1);
        add_cmd(ACT_ENQ, 5);
        add_cmd(ACT_ENQ, 5);
        for (k = 0; k < 8; k++)
            add_cmd(ACT_DEQ, (k % 2) ? VALUE_MIN : '1);
        add_cmd(ACT_ENQ, VALUE_MIN);
        add_cmd(ACT_DEQ, '0);
        add_cmd(ACT_DEQ, VALUE_MIN);

        // Random: segments biased toward filling, churning or draining
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n == 0)
            begin
                seg_len = 110;
                enq_pct = 95;
            end
            else
            begin
                seg_len = $urandom_range(40, 120);
                case ($urandom_range(2))
                    0:       enq_pct = 90;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            for (k = 0; k < seg_len && n < RANDOM_ITEMS; k++)
            begin
                act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
                add_cmd(act, pick_value());
                n++;
            end
        end

        // Single reset at the start
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results never seen", 64'(expected_results.size()), 64'd0);

        $display("Checked %0d commands and %0d results; peak occupancy %0d of %0d.",
                 cmds_sent, results_seen, peak_count, CAPACITY);
        $display("Saw %0d enqueues dropped while full, %0d dequeues on empty, %0d removals.",
                 full_drops, empty_deqs, removed_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
